### sv/srng_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srng_pkg
// Shared types, constants and microcode encodings for the bounded
// splitmix64 generator.
// ----------------------------------------------------------------------------
package srng_pkg;

   localparam int DATA_W = 64;
   localparam int HALF_W = DATA_W / 2;
   localparam int PC_W   = 6;

   localparam logic [DATA_W-1:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
   localparam logic [DATA_W-1:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
   localparam logic [DATA_W-1:0] MIX_MUL_B  = 64'h94d049bb133111eb;
   localparam int MIX_SHIFT_A = 30;
   localparam int MIX_SHIFT_B = 27;
   localparam int MIX_SHIFT_C = 31;

   localparam logic [1:0] OP_RAW     = 2'd0;
   localparam logic [1:0] OP_BOUNDED = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   // microprogram layout
   localparam logic [PC_W-1:0] RAW_ENTRY  = 6'd0;
   localparam logic [PC_W-1:0] RAW_OUT    = 6'd14;
   localparam logic [PC_W-1:0] BND_ENTRY  = 6'd15;
   localparam logic [PC_W-1:0] BND_WAIT_T = 6'd16;
   localparam logic [PC_W-1:0] BND_THR    = 6'd17;
   localparam logic [PC_W-1:0] BND_DRAW   = 6'd18;
   localparam logic [PC_W-1:0] BND_TEST   = 6'd32;
   localparam logic [PC_W-1:0] BND_DIV    = 6'd33;
   localparam logic [PC_W-1:0] BND_WAIT_V = 6'd34;
   localparam logic [PC_W-1:0] BND_OUT    = 6'd35;
   localparam logic [PC_W-1:0] RST_ENTRY  = 6'd36;
   localparam logic [PC_W-1:0] ERR_ENTRY  = 6'd37;
   localparam logic [PC_W-1:0] NOP_ENTRY  = 6'd38;
   localparam int DRAW_STEPS = 14;

   typedef struct packed {
      logic [1:0]        op;
      logic [DATA_W-1:0] bound;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              error;
   } rsp_type;

   typedef enum logic [1:0] {ST_NONE, ST_SEED, ST_STEP} st_op_type;
   typedef enum logic [2:0] {Z_NONE, Z_XS30, Z_XS27, Z_XS31, Z_ACC} z_op_type;
   typedef enum logic [1:0] {MUL_NONE, MUL_LL, MUL_LH, MUL_HL} mul_op_type;
   typedef enum logic [1:0] {ACC_NONE, ACC_SET, ACC_ADDHI} acc_op_type;
   typedef enum logic [1:0] {DIV_NONE, DIV_THR, DIV_VAL} div_op_type;
   typedef enum logic [1:0] {OUT_ZERO, OUT_Z, OUT_REM, OUT_ERR} out_op_type;
   typedef enum logic [1:0] {BR_NEXT, BR_WAIT, BR_LESS, BR_DONE} br_type;
   typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_type;

   typedef struct packed {
      st_op_type       st_op;
      z_op_type        z_op;
      mul_op_type      mul_op;
      logic            k_sel_b;
      acc_op_type      acc_op;
      div_op_type      div_op;
      logic            thr_load;
      out_op_type      out_op;
      br_type          br;
      logic [PC_W-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic div_busy;
      logic z_less_thr;
   } stat_type;

endpackage
`default_nettype wire

### sv/splitmix64_bounded_rng.sv
`default_nettype none
// ----------------------------------------------------------------------------
// splitmix64_bounded_rng
// SplitMix64 generator with raw draws, unbiased bounded draws and restart.
// ----------------------------------------------------------------------------
// One request at a time, one result beat per request. A bounded draw runs
// two remainder computations on the bit-serial divider and one or more
// draws, each 14 microcode steps through one shared 32x32 multiplier plus
// the threshold test, repeated while a draw is rejected. The last step of a
// request also waits while a stalled result still holds the output register.
// A new request is taken as soon as the previous one has moved its result
// into the output register, even if that result is still stalled. The seed
// register may be written at any time and is used at the next restart.
module splitmix64_bounded_rng
   import srng_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [DATA_W-1:0] csr_data
);

   logic     accept;
   logic     step_en;
   logic     emit;
   logic     slot_free;
   ctrl_type ctrl;
   stat_type stat;
   rsp_type  result;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff, rsp_in;

   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   srng_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .slot_free (slot_free),
      .stat      (stat),
      .req_stall (req_stall),
      .accept    (accept),
      .step_en   (step_en),
      .emit      (emit),
      .ctrl      (ctrl)
   );

   srng_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_valid && csr_ready),
      .csr_data (csr_data),
      .accept   (accept),
      .bound    (req_data.bound),
      .step_en  (step_en),
      .ctrl     (ctrl),
      .stat     (stat),
      .result   (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> slot_free)
      else $error("result written over a stalled beat");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.error) |-> (rsp_ff.value == '0))
      else $error("error beat carries a nonzero value");

endmodule
`default_nettype wire

### sv/srng_ucode_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srng_ucode_rom
// Microprogram store: one control word per step address.
// ----------------------------------------------------------------------------
module srng_ucode_rom
   import srng_pkg::*;
(
   input  wire logic [PC_W-1:0] pc,
   output ctrl_type             ctrl
);

   localparam ctrl_type CTRL_IDLE = '{
      st_op: ST_NONE, z_op: Z_NONE, mul_op: MUL_NONE, k_sel_b: 1'b0,
      acc_op: ACC_NONE, div_op: DIV_NONE, thr_load: 1'b0, out_op: OUT_ZERO,
      br: BR_NEXT, target: '0};

   // one splitmix64 draw, 64x64 products built from three 32x32 partials
   function automatic ctrl_type draw_step(input logic [3:0] k);
      ctrl_type c;
      c = CTRL_IDLE;
      case (k)
         4'd0:  c.st_op = ST_STEP;
         4'd1:  c.z_op = Z_XS30;
         4'd2:  c.mul_op = MUL_LL;
         4'd3:  begin c.mul_op = MUL_LH; c.acc_op = ACC_SET; end
         4'd4:  begin c.mul_op = MUL_HL; c.acc_op = ACC_ADDHI; end
         4'd5:  c.acc_op = ACC_ADDHI;
         4'd6:  c.z_op = Z_ACC;
         4'd7:  c.z_op = Z_XS27;
         4'd8:  begin c.mul_op = MUL_LL; c.k_sel_b = 1'b1; end
         4'd9:  begin c.mul_op = MUL_LH; c.k_sel_b = 1'b1; c.acc_op = ACC_SET; end
         4'd10: begin c.mul_op = MUL_HL; c.k_sel_b = 1'b1; c.acc_op = ACC_ADDHI; end
         4'd11: c.acc_op = ACC_ADDHI;
         4'd12: c.z_op = Z_ACC;
         4'd13: c.z_op = Z_XS31;
         default: c = CTRL_IDLE;
      endcase
      return c;
   endfunction

   always_comb begin
      ctrl = CTRL_IDLE;
      if (pc inside {[RAW_ENTRY : RAW_OUT - 6'd1]}) begin
         ctrl = draw_step(4'(pc - RAW_ENTRY));
      end else if (pc inside {[BND_DRAW : BND_TEST - 6'd1]}) begin
         ctrl = draw_step(4'(pc - BND_DRAW));
      end else begin
         case (pc)
            RAW_OUT: begin
               ctrl.out_op = OUT_Z;
               ctrl.br     = BR_DONE;
            end
            BND_ENTRY:  ctrl.div_op = DIV_THR;
            BND_WAIT_T: ctrl.br = BR_WAIT;
            BND_THR:    ctrl.thr_load = 1'b1;
            BND_TEST: begin
               ctrl.br     = BR_LESS;
               ctrl.target = BND_DRAW;
            end
            BND_DIV:    ctrl.div_op = DIV_VAL;
            BND_WAIT_V: ctrl.br = BR_WAIT;
            BND_OUT: begin
               ctrl.out_op = OUT_REM;
               ctrl.br     = BR_DONE;
            end
            RST_ENTRY: begin
               ctrl.st_op = ST_SEED;
               ctrl.br    = BR_DONE;
            end
            ERR_ENTRY: begin
               ctrl.out_op = OUT_ERR;
               ctrl.br     = BR_DONE;
            end
            NOP_ENTRY:  ctrl.br = BR_DONE;
            default:    ctrl.br = BR_DONE;
         endcase
      end
   end

endmodule
`default_nettype wire

### sv/srng_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srng_divider
// Bit-serial restoring divider, remainder only, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srng_divider
   import srng_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] dividend,
   input  wire logic [DATA_W-1:0] divisor,
   output logic                   busy,
   output logic [DATA_W-1:0]      rem
);

   localparam int CNT_W = $clog2(DATA_W + 1);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] dvd_ff, dvd_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;

   assign busy = (count_ff != '0);
   assign rem  = rem_ff;

   always_comb begin
      shifted  = {rem_ff, dvd_ff[DATA_W-1]};
      diff     = shifted - {1'b0, dvs_ff};
      count_in = count_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      rem_in   = rem_ff;
      if (start) begin
         count_in = CNT_W'(DATA_W);
         dvd_in   = dividend;
         dvs_in   = divisor;
         rem_in   = '0;
      end else if (busy) begin
         count_in = count_ff - 1'b1;
         dvd_in   = {dvd_ff[DATA_W-2:0], 1'b0};
         // no borrow means the trial subtraction fits
         rem_in   = (shifted >= {1'b0, dvs_ff}) ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy)
      else $error("divider did not go busy after start");

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rem_ff < dvs_ff))
      else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

### sv/srng_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srng_datapath
// Generator state, mixing registers, shared 32x32 multiplier, threshold
// register and the remainder unit, all driven by the control word.
// ----------------------------------------------------------------------------
module srng_datapath
   import srng_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [DATA_W-1:0] csr_data,
   input  wire logic              accept,
   input  wire logic [DATA_W-1:0] bound,
   input  wire logic              step_en,
   input  ctrl_type               ctrl,
   output stat_type               stat,
   output rsp_type                result
);

   logic [DATA_W-1:0] seed_ff, seed_in;
   logic [DATA_W-1:0] state_ff, state_in;
   logic [DATA_W-1:0] z_ff, z_in;
   logic [DATA_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] thr_ff, thr_in;
   logic [DATA_W-1:0] bound_ff, bound_in;
   logic [DATA_W-1:0] stepped;
   logic [DATA_W-1:0] mix_k;
   logic [HALF_W-1:0] mul_a, mul_b;
   logic              div_start;
   logic [DATA_W-1:0] div_dividend;
   logic              div_busy;
   logic [DATA_W-1:0] div_rem;

   srng_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (bound_ff),
      .busy     (div_busy),
      .rem      (div_rem)
   );

   assign stat.div_busy   = div_busy;
   assign stat.z_less_thr = (z_ff < thr_ff);

   always_comb begin
      stepped      = state_ff + GOLDEN_INC;
      mix_k        = ctrl.k_sel_b ? MIX_MUL_B : MIX_MUL_A;
      mul_a        = z_ff[HALF_W-1:0];
      mul_b        = mix_k[HALF_W-1:0];
      case (ctrl.mul_op)
         MUL_LH:  mul_b = mix_k[DATA_W-1:HALF_W];
         MUL_HL:  mul_a = z_ff[DATA_W-1:HALF_W];
         default: mul_b = mix_k[HALF_W-1:0];
      endcase

      seed_in  = csr_we ? csr_data : seed_ff;
      bound_in = accept ? bound : bound_ff;
      state_in = state_ff;
      z_in     = z_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      thr_in   = thr_ff;

      div_start    = 1'b0;
      div_dividend = z_ff;

      if (step_en) begin
         case (ctrl.st_op)
            ST_SEED: state_in = seed_ff;
            ST_STEP: begin
               state_in = stepped;
               z_in     = stepped;
            end
            default: state_in = state_ff;
         endcase
         case (ctrl.z_op)
            Z_XS30:  z_in = z_ff ^ (z_ff >> MIX_SHIFT_A);
            Z_XS27:  z_in = z_ff ^ (z_ff >> MIX_SHIFT_B);
            Z_XS31:  z_in = z_ff ^ (z_ff >> MIX_SHIFT_C);
            Z_ACC:   z_in = acc_ff;
            default: ;
         endcase
         if (ctrl.mul_op != MUL_NONE) begin
            prod_in = DATA_W'(mul_a) * DATA_W'(mul_b);
         end
         case (ctrl.acc_op)
            ACC_SET:   acc_in = prod_ff;
            // cross partials only reach the upper half
            ACC_ADDHI: acc_in = acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
            default:   acc_in = acc_ff;
         endcase
         case (ctrl.div_op)
            DIV_THR: begin
               div_start    = 1'b1;
               div_dividend = '0 - bound_ff;
            end
            DIV_VAL: div_start = 1'b1;
            default: div_start = 1'b0;
         endcase
         if (ctrl.thr_load) begin
            thr_in = div_rem;
         end
      end
   end

   always_comb begin
      case (ctrl.out_op)
         OUT_Z:   result = '{value: z_ff, error: 1'b0};
         OUT_REM: result = '{value: div_rem, error: 1'b0};
         OUT_ERR: result = '{value: '0, error: 1'b1};
         default: result = '{value: '0, error: 1'b0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= '0;
         state_ff <= '0;
      end else begin
         seed_ff  <= seed_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff     <= z_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      thr_ff   <= thr_in;
      bound_ff <= bound_in;
   end

endmodule
`default_nettype wire

### sv/srng_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srng_sequencer
// Step counter over the microprogram: dispatch on the request opcode,
// wait on the divider, retry on rejection, finish into the result slot.
// ----------------------------------------------------------------------------
module srng_sequencer
   import srng_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  req_type   req_data,
   input  wire logic slot_free,
   input  stat_type  stat,
   output logic      req_stall,
   output logic      accept,
   output logic      step_en,
   output logic      emit,
   output ctrl_type  ctrl
);

   seq_state_type   state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic [PC_W-1:0] entry;

   srng_ucode_rom u_rom (
      .pc   (pc_ff),
      .ctrl (ctrl)
   );

   always_comb begin
      case (req_data.op)
         OP_RAW:     entry = RAW_ENTRY;
         OP_BOUNDED: entry = (req_data.bound == '0) ? ERR_ENTRY : BND_ENTRY;
         OP_RESTART: entry = RST_ENTRY;
         default:    entry = NOP_ENTRY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      req_stall = (state_ff != SEQ_IDLE);
      accept    = 1'b0;
      step_en   = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               accept   = 1'b1;
               pc_in    = entry;
               state_in = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            // a finishing step holds until the result slot can take the beat
            step_en = (ctrl.br != BR_DONE) || slot_free;
            if (step_en) begin
               case (ctrl.br)
                  BR_WAIT: pc_in = stat.div_busy ? pc_ff : pc_ff + 1'b1;
                  BR_LESS: pc_in = stat.z_less_thr ? ctrl.target : pc_ff + 1'b1;
                  BR_DONE: begin
                     emit     = 1'b1;
                     state_in = SEQ_IDLE;
                  end
                  default: pc_in = pc_ff + 1'b1;
               endcase
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

endmodule
`default_nettype wire
